// ----- hw/rtl/mms_pkg.sv -----
`timescale 1ns / 1ps
package mms_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 7;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_e;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] cur_min;
    logic signed [DATA_W-1:0] cur_max;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    status_e                  status;
  } out_t;

  // One stack entry: the value with the running min and max at its push.
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] min;
    logic signed [DATA_W-1:0] max;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// ----- hw/rtl/mms_ctrl.sv -----
`timescale 1ns / 1ps
module mms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mms_pkg::stat_t    stat_i,
  output mms_pkg::cmd_t     cmd_o
);

  mms_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mms_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    case (state_q)
      mms_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mms_pkg::S_EMIT;
        end
      end
      mms_pkg::S_EMIT: begin
        // The operation is applied only once the result register has room.
        if (!stat_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = mms_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mms_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mms_datapath.sv -----
`timescale 1ns / 1ps
module mms_datapath #(
  parameter int unsigned DEPTH = mms_pkg::STACK_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mms_pkg::in_t    in_data_i,
  input  mms_pkg::cmd_t   cmd_i,
  output mms_pkg::stat_t  stat_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mms_pkg::out_t   out_data_o
);

  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned IDXW = $clog2(DEPTH);

  mms_pkg::entry_t mem [DEPTH];
  mms_pkg::entry_t rd_q;
  mms_pkg::entry_t top_q, top_d;
  mms_pkg::entry_t wentry;
  mms_pkg::in_t    item_q;
  mms_pkg::out_t   out_q, out_d;
  mms_pkg::status_e status;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CNTW-1:0] below_cnt;
  logic [IDXW-1:0] raddr;
  logic [IDXW-1:0] waddr;
  logic            we;
  logic            out_valid_q;
  logic signed [mms_pkg::DATA_W-1:0] popped;

  // The entry under the top sits at count - 2; it is fetched at the transfer
  // so that a pop can refill the top registers when it executes.
  assign below_cnt = cnt_q - CNTW'(2);
  assign raddr     = below_cnt[IDXW-1:0];
  assign waddr     = cnt_q[IDXW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wentry;
    end
    if (cmd_i.capture) begin
      rd_q <= mem[raddr];
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    top_d  = top_q;
    we     = 1'b0;
    wentry = '0;
    status = mms_pkg::ST_OK;
    popped = '0;
    if (item_q.op == mms_pkg::OP_POP) begin
      if (cnt_q == '0) begin
        status = mms_pkg::ST_POP_EMPTY;
      end else begin
        cnt_d  = cnt_q - CNTW'(1);
        popped = top_q.val;
        top_d  = rd_q;
      end
    end else begin
      if (cnt_q == CNTW'(DEPTH)) begin
        status = mms_pkg::ST_PUSH_FULL;
      end else begin
        wentry.val = item_q.value;
        wentry.min = item_q.value;
        wentry.max = item_q.value;
        if (cnt_q != '0) begin
          if (top_q.min < item_q.value) wentry.min = top_q.min;
          if (top_q.max > item_q.value) wentry.max = top_q.max;
        end
        we    = cmd_i.exec;
        top_d = wentry;
        cnt_d = cnt_q + CNTW'(1);
      end
    end
  end

  always_comb begin
    out_d          = '0;
    out_d.popped   = popped;
    out_d.count    = mms_pkg::COUNT_W'(cnt_d);
    out_d.is_empty = (cnt_d == '0);
    out_d.status   = status;
    if (cnt_d != '0) begin
      out_d.cur_min = top_d.min;
      out_d.cur_max = top_d.max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      top_q <= top_d;
      out_q <= out_d;
    end
  end

  assign stat_o.out_busy = out_valid_q & out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ----- hw/rtl/min_max_stack.sv -----
`timescale 1ns / 1ps
// Stack of signed 32-bit values that reports the running minimum and maximum.
// Input channel in_valid_i / in_stall_o carries one operation (push a value or
// pop the top entry); the output channel out_valid_o / out_stall_i returns one
// result per operation with the popped value, the minimum, maximum and count
// after the step, an empty flag and a status code. A pop on an empty stack or
// a push onto a full one is refused with a status code and changes nothing.
// Each operation has a transfer cycle, in which the entry below the top is
// read from the synchronous stack memory, and an execute cycle that updates
// the top-of-stack registers and loads the result register; a stalled result
// can hold an item between them. The result is valid the cycle after
// execution. A new item is taken only once the last one has executed.
// A new item is taken while a finished result still waits.
// When the receiver stalls with a result pending, the next item is accepted
// and then held before execution until the result register frees up.
// Reset empties the stack and clears the output valid; the memory contents
// need no clearing because values read at or above the count are never used.
module min_max_stack #(
  parameter int unsigned STACK_DEPTH = mms_pkg::STACK_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mms_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mms_pkg::out_t out_data_o
);

  mms_pkg::cmd_t  cmd;
  mms_pkg::stat_t stat;

  mms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mms_datapath #(
    .DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/mms_checker.sv -----
`timescale 1ns / 1ps
module mms_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input mms_pkg::out_t out_data_o,
  input logic          out_valid_o,
  input logic          out_stall_i
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // After a transfer the block needs its execute cycle.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken during execute cycle");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |->
      out_data_o.count == '0 && out_data_o.cur_min == '0 && out_data_o.cur_max == '0)
    else $error("empty stack reports nonzero fields");

  a_refused_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != mms_pkg::ST_OK |-> out_data_o.popped == '0)
    else $error("refused operation returned a value");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_empty |-> out_data_o.cur_min <= out_data_o.cur_max)
    else $error("minimum above maximum");

endmodule

bind min_max_stack mms_checker u_mms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
